// ===== rtl/core/tgarle_pkg.sv =====
// shared types and constants for the tga run-length pixel decoder
package tgarle_pkg;

   // packet header split point: below this a raw packet, else a run
   localparam logic [7:0] RUN_FLAG_VALUE = 8'd128;
   localparam logic [7:0] RUN_BIAS       = 8'd127;

   // index of the last byte of a pixel for each pixel size
   localparam logic [1:0] LAST_IDX_24 = 2'd2;
   localparam logic [1:0] LAST_IDX_32 = 2'd3;

   // configuration register indexes
   localparam logic CSR_PIXEL_COUNT = 1'b0;
   localparam logic CSR_FOUR_BYTE   = 1'b1;

   // one decoded pixel or run, as it travels from front to back
   typedef struct packed {
      logic       clipped;
      logic       image_done;
      logic [7:0] repeat_res;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_item_type;

endpackage

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// top level of the tga run-length pixel decoder
//
// Usage:
//   req_* carries the coded pixel stream of a TGA image, one byte per request
//   (packet headers and BGR or BGRA colour bytes). rsp_* returns one result per
//   decoded pixel or run: RGBA colour, a repeat count of 1 to 128, tlast when
//   the image's pixel count is reached and tuser when that packet was cut.
//   csr_* writes the pixel count (index 0) and the pixel size (index 1, set for
//   four-byte pixels); write only while no request is in flight.
// Throughput: one request per cycle while the queue has room, set by the
//   front-end state update; header bytes and leading colour bytes give no
//   result. A pixel's result goes from the front into the queue and from
//   the queue into the output register before rsp_tvalid rises.
// Reset: decoding state clears, the next byte is taken as a packet header,
//   pixel count returns to 1 and the pixel size to three bytes.
// Stall: when rsp_tready is low the output register and then the queue fill;
//   req_tready drops once the queue is full and rises again as results drain.
module tga_rle_pixel_decoder import tgarle_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request: data_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // response: red, green, blue, alpha, repeat_res
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   // response flag: clipped
   output logic        rsp_tuser,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0]    pixel_count_ff;
   logic           four_byte_ff;
   logic           front_valid;
   logic           front_ready;
   pixel_item_type front_item;
   logic           queue_valid;
   logic           queue_ready;
   pixel_item_type queue_item;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= 32'd1;
         four_byte_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIXEL_COUNT: pixel_count_ff <= csr_data;
            CSR_FOUR_BYTE:   four_byte_ff   <= csr_data[0];
            default:         pixel_count_ff <= pixel_count_ff;
         endcase
      end
   end

   // header parsing and pixel assembly
   tgarle_front u_front (
      .clock            (clock),
      .reset            (reset),
      .byte_valid       (req_tvalid),
      .byte_ready       (req_tready),
      .data_byte        (req_tdata),
      .pixel_count      (pixel_count_ff),
      .four_byte_pixels (four_byte_ff),
      .item_valid       (front_valid),
      .item_ready       (front_ready),
      .item             (front_item)
   );

   // decoupling queue
   tgarle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   // output register
   tgarle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/tgarle_front.sv =====
// front end: packet header parsing, pixel assembly and image-end clipping
module tgarle_front import tgarle_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_valid,
   output logic           byte_ready,
   input  logic [7:0]     data_byte,
   input  logic [31:0]    pixel_count,
   input  logic           four_byte_pixels,
   output logic           item_valid,
   input  logic           item_ready,
   output pixel_item_type item
);

   logic        expect_header_ff, expect_header_in;
   logic        run_packet_ff, run_packet_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [23:0] colour_hold_ff, colour_hold_in;
   logic [31:0] pixels_done_ff, pixels_done_in;

   logic        accept;
   logic [1:0]  last_idx;
   logic        final_byte;
   logic [23:0] colour_final;
   logic [7:0]  alpha_final;
   logic [31:0] total;
   logic [31:0] remaining;
   logic [7:0]  count_raw;
   logic [7:0]  count;
   logic        done;
   logic [7:0]  leftover;

   // a request is taken whenever the queue has room
   assign byte_ready = item_ready;
   assign accept     = byte_valid && byte_ready;

   assign last_idx   = four_byte_pixels ? LAST_IDX_32 : LAST_IDX_24;
   assign final_byte = !expect_header_ff && (byte_in_pixel_ff >= last_idx);

   // colour of a finished pixel, red taken from the last byte in 24-bit mode
   always_comb begin
      if (four_byte_pixels) begin
         colour_final = colour_hold_ff;
         alpha_final  = data_byte;
      end else begin
         colour_final = {data_byte, colour_hold_ff[15:0]};
         alpha_final  = 8'd0;
      end
   end

   // repeat count against what is left of the image
   always_comb begin
      total     = (pixel_count == 32'd0) ? 32'd1 : pixel_count;
      remaining = (total > pixels_done_ff) ? (total - pixels_done_ff) : 32'd1;
      count_raw = run_packet_ff ? packet_left_ff : 8'd1;
      if (count_raw == 8'd0) begin
         count_raw = 8'd1;
      end
      done  = ({24'd0, count_raw} >= remaining);
      count = done ? remaining[7:0] : count_raw;
      leftover = (packet_left_ff > count) ? (packet_left_ff - count) : 8'd0;
   end

   // result toward the queue
   always_comb begin
      item.red        = colour_final[23:16];
      item.green      = colour_final[15:8];
      item.blue       = colour_final[7:0];
      item.alpha      = alpha_final;
      item.repeat_res = count;
      item.image_done = done;
      item.clipped    = done && (leftover != 8'd0);
   end
   assign item_valid = accept && final_byte;

   // decoder state update
   always_comb begin
      expect_header_in = expect_header_ff;
      run_packet_in    = run_packet_ff;
      packet_left_in   = packet_left_ff;
      byte_in_pixel_in = byte_in_pixel_ff;
      colour_hold_in   = colour_hold_ff;
      pixels_done_in   = pixels_done_ff;
      if (accept) begin
         if (expect_header_ff) begin
            run_packet_in    = (data_byte >= RUN_FLAG_VALUE);
            packet_left_in   = (data_byte >= RUN_FLAG_VALUE) ? (data_byte - RUN_BIAS)
                                                             : (data_byte + 8'd1);
            byte_in_pixel_in = 2'd0;
            expect_header_in = 1'b0;
         end else if (!final_byte) begin
            unique case (byte_in_pixel_ff)
               2'd0:    colour_hold_in[7:0]   = data_byte;
               2'd1:    colour_hold_in[15:8]  = data_byte;
               default: colour_hold_in[23:16] = data_byte;
            endcase
            byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
         end else begin
            byte_in_pixel_in = 2'd0;
            colour_hold_in   = 24'd0;
            if (done) begin
               pixels_done_in   = 32'd0;
               packet_left_in   = 8'd0;
               expect_header_in = 1'b1;
            end else begin
               pixels_done_in   = pixels_done_ff + {24'd0, count};
               packet_left_in   = leftover;
               expect_header_in = (leftover == 8'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         run_packet_ff    <= 1'b0;
         packet_left_ff   <= 8'd0;
         byte_in_pixel_ff <= 2'd0;
         colour_hold_ff   <= 24'd0;
         pixels_done_ff   <= 32'd0;
      end else begin
         expect_header_ff <= expect_header_in;
         run_packet_ff    <= run_packet_in;
         packet_left_ff   <= packet_left_in;
         byte_in_pixel_ff <= byte_in_pixel_in;
         colour_hold_ff   <= colour_hold_in;
         pixels_done_ff   <= pixels_done_in;
      end
   end

endmodule

// ===== rtl/core/tgarle_queue.sv =====
// short queue of decoded pixels between front and back
module tgarle_queue import tgarle_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  pixel_item_type push_item,
   output logic           pop_valid,
   input  logic           pop_ready,
   output pixel_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   pixel_item_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/tgarle_back.sv =====
// back end: registered result stage that drives the response channel
module tgarle_back import tgarle_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   output logic           item_ready,
   input  pixel_item_type item,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [39:0]    rsp_tdata,
   output logic           rsp_tlast,
   output logic           rsp_tuser
);

   logic           valid_ff, valid_in;
   pixel_item_type data_ff;

   // load a new result when the stage is empty or being drained
   assign item_ready = !valid_ff || rsp_tready;
   assign valid_in   = item_ready ? item_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_ready && item_valid) begin
         data_ff <= item;
      end
   end

   // pack the response
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.repeat_res, data_ff.alpha, data_ff.blue,
                        data_ff.green, data_ff.red};
   assign rsp_tlast  = data_ff.image_done;
   assign rsp_tuser  = data_ff.clipped;

endmodule

// ===== test/tga_rle_checker.sv =====
// pixel result checker for the tga run-length decoder: predicts and compares
`timescale 1ns / 1ps

module tga_rle_checker import tgarle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          outstanding
);

   // configuration as the decoder should hold it
   logic [31:0] pixel_count_reg;
   logic        four_byte_reg;

   // decoding state
   logic        awaiting_header;
   logic        in_run;
   logic [31:0] packet_left;
   logic [1:0]  byte_slot;
   logic [23:0] colour_bytes;
   logic [31:0] image_pixels;

   pixel_item_type pending_pixels[$];
   int             error_count;

   // one stream byte into the decoder state, queueing any pixel it completes
   task automatic decode_byte(input logic [7:0] b);
      logic [1:0]     last_slot;
      logic [31:0]    total;
      logic [31:0]    remaining;
      logic [31:0]    span;
      logic [31:0]    leftover;
      pixel_item_type pix;
      last_slot = four_byte_reg ? LAST_IDX_32 : LAST_IDX_24;
      if (awaiting_header) begin
         in_run          = (b >= RUN_FLAG_VALUE);
         packet_left     = in_run ? {24'd0, b} - RUN_BIAS : {24'd0, b} + 32'd1;
         byte_slot       = 2'd0;
         awaiting_header = 1'b0;
      end else if (byte_slot < last_slot) begin
         colour_bytes[8 * byte_slot +: 8] = b;
         byte_slot = byte_slot + 2'd1;
      end else begin
         // last byte of the pixel: red in three-byte mode, alpha in four-byte mode
         pix.alpha = 8'd0;
         if (last_slot == LAST_IDX_24) begin
            colour_bytes[23:16] = b;
         end else begin
            pix.alpha = b;
         end
         byte_slot = 2'd0;

         // clip the repeat at the end of the image
         total     = (pixel_count_reg != 32'd0) ? pixel_count_reg : 32'd1;
         remaining = (total > image_pixels) ? total - image_pixels : 32'd1;
         span      = in_run ? packet_left : 32'd1;
         if (span == 32'd0) begin
            span = 32'd1;
         end
         pix.image_done = 1'b0;
         if (span >= remaining) begin
            span           = remaining;
            pix.image_done = 1'b1;
         end
         leftover = (packet_left > span) ? packet_left - span : 32'd0;

         pix.red        = colour_bytes[23:16];
         pix.green      = colour_bytes[15:8];
         pix.blue       = colour_bytes[7:0];
         pix.repeat_res = span[7:0];
         pix.clipped    = pix.image_done && (leftover != 32'd0);
         pending_pixels = {pending_pixels, pix};

         colour_bytes = 24'd0;
         if (pix.image_done) begin
            image_pixels    = 32'd0;
            packet_left     = 32'd0;
            awaiting_header = 1'b1;
         end else begin
            image_pixels = image_pixels + span;
            packet_left  = leftover;
            if (packet_left == 32'd0) begin
               awaiting_header = 1'b1;
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // compare responses first, then apply register writes and requests
   always @(posedge clock) begin
      pixel_item_type want;
      if (reset) begin
         pixel_count_reg = 32'd1;
         four_byte_reg   = 1'b0;
         awaiting_header = 1'b1;
         in_run          = 1'b0;
         packet_left     = 32'd0;
         byte_slot       = 2'd0;
         colour_bytes    = 24'd0;
         image_pixels    = 32'd0;
         error_count     = 0;
         pending_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected pixel result, expected none, actual %h last %b user %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = pending_pixels.pop_front();
               check_field("red", want.red, rsp_tdata[7:0]);
               check_field("green", want.green, rsp_tdata[15:8]);
               check_field("blue", want.blue, rsp_tdata[23:16]);
               check_field("alpha", want.alpha, rsp_tdata[31:24]);
               check_field("repeat", want.repeat_res, rsp_tdata[39:32]);
               check_field("image_done", {7'd0, want.image_done}, {7'd0, rsp_tlast});
               check_field("clipped", {7'd0, want.clipped}, {7'd0, rsp_tuser});
            end
         end

         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PIXEL_COUNT) begin
               pixel_count_reg = csr_data;
            end else begin
               four_byte_reg = csr_data[0];
            end
         end

         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata);
         end
      end
      fail_count  <= error_count;
      outstanding <= pending_pixels.size();
   end

endmodule

// ===== test/tb_tga_rle_pixel_decoder.sv =====
// testbench top for the tga run-length decoder: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;
   import tgarle_pkg::*;

   localparam int          SETTLE_CYCLES = 8;
   localparam int          HOLD_CYCLES   = 200;
   localparam int          PHASE_BYTES   = 95;
   localparam int unsigned RUN_LIMIT_NS  = 2_000_000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;
   int          fail_count;
   int          outstanding;

   // flow control knobs
   int          req_idle_pct;
   int          rsp_stall_pct = 0;
   logic        hold_kick     = 1'b0;
   logic        hold_seen     = 1'b0;
   int          hold_count    = 0;

   // stimulus-side view of the image, to keep packets inside it
   logic [31:0] mirror_count;
   logic        mirror_four;
   logic [31:0] mirror_done;
   int          bytes_sent;

   tga_rle_pixel_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tga_rle_checker pixel_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   // response side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_kick != hold_seen) begin
         hold_seen  <= hold_kick;
         hold_count <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // one request byte, after random idle cycles
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // one register write, followed by an idle gap with csr_valid low
   task automatic write_csr(input logic index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (index == CSR_PIXEL_COUNT) begin
         mirror_count = value;
      end else begin
         mirror_four = value[0];
      end
   endtask

   // stop sending and wait until every expected pixel has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixel();
      repeat (mirror_four ? 4 : 3) send_byte(8'($urandom_range(255)));
   endtask

   // a well-formed packet kept inside the image, or at times junk bytes when noisy
   task automatic send_packet(input logic noisy);
      int          n;
      logic        run;
      logic [31:0] total;
      logic [31:0] remaining;
      if (noisy && $urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
         return;
      end
      run = 1'($urandom_range(1));
      n   = ($urandom_range(19) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
      send_byte(run ? 8'(n + 127) : 8'(n - 1));
      total     = (mirror_count != 32'd0) ? mirror_count : 32'd1;
      remaining = (total > mirror_done) ? total - mirror_done : 32'd1;
      if (run) begin
         send_pixel();
      end else begin
         repeat ((n < remaining) ? n : remaining) send_pixel();
      end
      if (n >= remaining) begin
         mirror_done = 32'd0;
      end else begin
         mirror_done = mirror_done + n;
      end
   endtask

   task automatic run_phase(input logic [31:0] count, input logic four, input int idle_pct,
                            input int stall_pct, input logic noisy);
      int phase_end;
      write_csr(CSR_PIXEL_COUNT, count);
      write_csr(CSR_FOUR_BYTE, {31'd0, four});
      req_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_packet(noisy);
      settle();
   endtask

   // stimulus and verdict
   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= 8'd0;
      csr_valid    <= 1'b0;
      csr_index    <= CSR_PIXEL_COUNT;
      csr_data     <= 32'd0;
      req_idle_pct = 0;
      mirror_count = 32'd1;
      mirror_four  = 1'b0;
      mirror_done  = 32'd0;
      bytes_sent   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero pixel count: every pixel ends an image
      write_csr(CSR_PIXEL_COUNT, 32'd0);
      write_csr(CSR_FOUR_BYTE, 32'd0);
      send_byte(8'h00);
      repeat (3) send_byte(8'h00);
      // longest raw packet, cut after its first pixel
      send_byte(8'h7F);
      repeat (3) send_byte(8'hFF);
      settle();

      // longest run, then a raw packet of three stopped after one pixel
      write_csr(CSR_PIXEL_COUNT, 32'd200);
      write_csr(CSR_FOUR_BYTE, 32'd1);
      send_byte(8'hFF);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      send_byte(8'h44);
      send_byte(8'h02);
      send_byte(8'hA1);
      send_byte(8'hB2);
      send_byte(8'hC3);
      send_byte(8'hD4);
      settle();

      // count lowered below progress: next pixel ends the image, clipped
      write_csr(CSR_PIXEL_COUNT, 32'd100);
      send_byte(8'h5E);
      send_byte(8'h6F);
      send_byte(8'h70);
      send_byte(8'h81);
      settle();

      // shortest run, pixel size dropped to three bytes after its third byte
      write_csr(CSR_PIXEL_COUNT, 32'hFFFE_0001);
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h03);
      settle();
      write_csr(CSR_FOUR_BYTE, 32'd0);
      send_byte(8'h09);
      settle();
      // one pixel of the current image is done at this point
      mirror_done = 32'd1;

      // random phases; the first one starts with a long receiver hold-off
      hold_kick <= ~hold_kick;
      run_phase(32'd7, 1'b0, 0, 0, 1'b0);
      run_phase(32'd20, 1'b1, 75, 0, 1'b0);
      run_phase(32'h0001_FFFE, 1'b0, 0, 75, 1'b0);
      run_phase(32'($urandom_range(1, 40)), 1'b1, 38, 38, 1'b1);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tgarle_pkg.sv
rtl/core/tgarle_front.sv
rtl/core/tgarle_queue.sv
rtl/core/tgarle_back.sv
rtl/core/tga_rle_pixel_decoder.sv
test/tga_rle_checker.sv
test/tb_tga_rle_pixel_decoder.sv
